FILE: hdl/pss_pkg.sv
// Package for the prime set sorter: status codes and command codes.
// No dependencies.
`default_nettype none
package pss_pkg;
    localparam logic       CMD_OFFER    = 1'b0;
    localparam logic       CMD_READOUT  = 1'b1;
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_NOT_PRIME = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam int         STATUS_BITS  = 3;
    localparam int         COUNT_BITS   = 7;
endpackage
`default_nettype wire

FILE: hdl/pss_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/pss_divider.sv
// Restoring remainder unit: one quotient bit a cycle, reports zero remainder.
// No dependencies.
`default_nettype none
module pss_divider #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [VALUE_BITS-1:0] i_divisor,
    output logic                       o_done,
    output logic                       o_zero_rem
);
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_num, n_num;
    logic [VALUE_BITS-1:0] r_den;
    logic [VALUE_BITS:0]   r_rem, n_rem;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic [VALUE_BITS:0]   w_shift;

    // shift in one dividend bit and subtract if it fits
    always_comb begin
        w_shift = {r_rem[VALUE_BITS-1:0], r_num[VALUE_BITS-1]};
        n_num   = {r_num[VALUE_BITS-2:0], 1'b0};
        if (w_shift >= {1'b0, r_den}) begin
            n_rem = w_shift - {1'b0, r_den};
        end else begin
            n_rem = w_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(VALUE_BITS);
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_zero_rem = (r_rem == '0);
endmodule
`default_nettype wire

FILE: hdl/prime_set_sorter_unit.sv
// Top level of the prime set sorter: sequencer around the table RAM and divider.
// Depends on pss_pkg, pss_ram, pss_divider.
//
//  channel | ports                                      | handshake
//  command | i_cmd, i_number                            | i_start & !o_busy
//  result  | o_status, o_entry_value, o_entry_count, o_last | o_valid, one cycle
//
// An offer trial-divides by each divisor from 2 while its square is at most n,
// then scans the held entries for a duplicate. A readout runs an exchange sort,
// comparing each pair and writing both words back on a swap, then puts out one
// word per held entry.
// Reset clears the fill count and sequencer; table contents stay undefined.
// The receiver cannot stall; o_busy holds off new commands until the last word.
`default_nettype none
module prime_set_sorter_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_cmd,
    input  wire logic [15:0]           i_number,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [15:0]                o_entry_value,
    output logic [6:0]                 o_entry_count,
    output logic                       o_last
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_DIVW = 4'd2,
        S_SCAN = 4'd3, S_SCANW = 4'd4, S_SCANC = 4'd5, S_RI = 4'd6,
        S_RJ = 4'd7, S_CMP = 4'd8, S_WB = 4'd9, S_OUTR = 4'd10,
        S_OUTW = 4'd11, S_DONE = 4'd12;

    logic [3:0]            r_state;
    logic [VALUE_BITS-1:0] r_num, r_d, r_a;
    logic [CW-1:0]         r_fill, r_i, r_j;
    logic                  r_dupe;
    logic [2:0]            r_st;
    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [VALUE_BITS-1:0] w_wdata, w_rdata;
    logic                  w_div_start, w_div_done, w_zero;
    logic [2*VALUE_BITS-1:0] w_sq;
    logic                  r_wb2;

    pss_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    pss_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(r_num), .i_divisor(r_d), .o_done(w_div_done),
        .o_zero_rem(w_zero)
    );

    assign w_sq        = r_d * r_d;
    assign w_div_start = (r_state == S_DIV) && (w_sq <= {{VALUE_BITS{1'b0}}, r_num});
    assign o_busy      = (r_state != S_IDLE);

    // RAM address and write selection per state
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_fill[AW-1:0];
        w_wdata = r_num;
        w_raddr = r_i[AW-1:0];
        unique case (r_state)
            S_SCAN:  w_raddr = r_i[AW-1:0];
            S_RJ:    w_raddr = r_j[AW-1:0];
            S_SCANC: begin
                w_we = (r_i == r_fill) && !r_dupe && (r_fill < CW'(TABLE_DEPTH));
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = r_wb2 ? r_j[AW-1:0] : r_i[AW-1:0];
                w_wdata = r_wb2 ? r_a : r_num;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    // latch the offered value; a readout reports zero if empty
                    r_num <= (i_cmd == pss_pkg::CMD_OFFER) ?
                             VALUE_BITS'(i_number) : '0;
                    r_i   <= '0;
                    r_j   <= CW'(1);
                    r_dupe <= 1'b0;
                    if (i_cmd == pss_pkg::CMD_OFFER) begin
                        r_d <= VALUE_BITS'(2);
                        if (VALUE_BITS'(i_number) < VALUE_BITS'(2)) begin
                            r_st    <= pss_pkg::ST_NOT_PRIME;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else if (r_fill == '0) begin
                        r_st    <= pss_pkg::ST_EMPTY;
                        r_state <= S_DONE;
                    end else if (r_fill == CW'(1)) begin
                        r_state <= S_OUTR;
                    end else begin
                        r_state <= S_RI;
                    end
                end
                S_DIV: begin
                    if (w_div_start) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_DIVW: if (w_div_done) begin
                    if (w_zero) begin
                        r_st    <= pss_pkg::ST_NOT_PRIME;
                        r_state <= S_DONE;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_SCAN: begin
                    r_state <= (r_i == r_fill) ? S_SCANC : S_SCANW;
                end
                S_SCANW: begin
                    if (w_rdata == r_num) begin
                        r_dupe <= 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCANC: begin
                    if (r_dupe) begin
                        r_st <= pss_pkg::ST_DUPLICATE;
                    end else if (r_fill >= CW'(TABLE_DEPTH)) begin
                        r_st <= pss_pkg::ST_FULL;
                    end else begin
                        r_st   <= pss_pkg::ST_INSERTED;
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_RI: r_state <= S_RJ;
                S_RJ: begin
                    r_a     <= w_rdata;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_a < w_rdata) begin
                        r_num   <= w_rdata;
                        r_wb2   <= 1'b0;
                        r_state <= S_WB;
                    end else if (r_j + 1'b1 == r_fill) begin
                        if (r_i + CW'(2) == r_fill) begin
                            r_i <= '0;
                            r_state <= S_OUTR;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= r_i + CW'(2);
                            r_state <= S_RI;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RI;
                    end
                end
                S_WB: begin
                    if (!r_wb2) begin
                        r_wb2 <= 1'b1;
                    end else if (r_j + 1'b1 == r_fill) begin
                        if (r_i + CW'(2) == r_fill) begin
                            r_i <= '0;
                            r_state <= S_OUTR;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= r_i + CW'(2);
                            r_state <= S_RI;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RI;
                    end
                end
                S_OUTR: r_state <= S_OUTW;
                S_OUTW: begin
                    o_valid       <= 1'b1;
                    o_status      <= pss_pkg::ST_ENTRY;
                    o_entry_value <= 16'(w_rdata);
                    o_entry_count <= 7'(r_fill);
                    o_last        <= (r_i + 1'b1 == r_fill);
                    r_i           <= r_i + 1'b1;
                    r_state       <= (r_i + 1'b1 == r_fill) ? S_IDLE : S_OUTR;
                end
                S_DONE: begin
                    o_valid       <= 1'b1;
                    o_status      <= r_st;
                    o_entry_value <= 16'(r_num);
                    o_entry_count <= 7'(r_fill);
                    o_last        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // fill count never passes the table size
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
    // a result word marked last always finds the block back in idle
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == S_IDLE)) else $error("last without idle");
    // fill count moves only upward, and only by one
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count jump");
`endif
endmodule
`default_nettype wire
